[hw/rtl/nearest_vertex_to_ray_unit_macros.svh]
// Assertion shorthands shared by the RTL.
`ifndef NEAREST_VERTEX_TO_RAY_UNIT_MACROS_SVH
`define NEAREST_VERTEX_TO_RAY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NVR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/nvr_pkg.sv]
`timescale 1ns / 1ps
package nvr_pkg;

  localparam int CoordW      = 12;               // Q3.8 coordinate
  localparam int RadiusW     = CoordW - 1;       // unsigned Q3.8 radius
  localparam int WW          = CoordW + 1;       // v - origin
  localparam int CrossW      = 2 * CoordW + 2;   // cross product component
  localparam int MagW        = CrossW - 1;       // |cross| magnitude
  localparam int SqW         = 2 * MagW;         // squared component
  localparam int SumW        = SqW + 2;          // metric, sum of three squares
  localparam int MetricW     = 56;               // best metric register
  localparam int RrW         = 2 * RadiusW;      // radius squared
  localparam int DsqW        = 2 * CoordW;       // |dir|^2
  localparam int ThrW        = RrW + DsqW;       // threshold
  localparam int MaxVertices = 4096;
  localparam int PosW        = $clog2(MaxVertices);
  localparam int CntW        = PosW + 1;
  localparam int FifoDepth   = 4;
  localparam int CfgIdxW     = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOriginX   = 3'd0,
    CfgOriginY   = 3'd1,
    CfgOriginZ   = 3'd2,
    CfgDirX      = 3'd3,
    CfgDirY      = 3'd4,
    CfgDirZ      = 3'd5,
    CfgPickRadius = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic            last;
    logic [SumW-1:0] metric;
  } q_item_t;

endpackage

[hw/rtl/nvr_if.sv]
`timescale 1ns / 1ps
interface vertex_if import nvr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] vertex_x;
  logic signed [CoordW-1:0] vertex_y;
  logic signed [CoordW-1:0] vertex_z;
  logic                     final_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, final_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, final_vertex, output ready);
endinterface

interface result_if import nvr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            hit;
  logic [PosW-1:0] vertex_index;

  modport source (output valid, hit, vertex_index, input ready);
  modport sink (input valid, hit, vertex_index, output ready);
endinterface

interface cfg_if import nvr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CoordW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/nearest_vertex_to_ray_unit.sv]
// With the queue empty, the final vertex passes the 3 metric stages, the queue write
// and then the result register before res valid rises.
// Throughput: one vertex per cycle unless the queue or result stalls; the metric pipe
// is 3 stages, then a 4-entry queue, then a back-end compare loop that sets the rate.
// Reset (async, active low): ray = origin 0, dir (0,0,1), radius 0; scan state cleared.
// A config write reaches the pick threshold via its register, rr_q/dsq_q, then thr_q.
`timescale 1ns / 1ps
module nearest_vertex_to_ray_unit import nvr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfg_if.sink       cfg_i,
  vertex_if.sink    vtx_i,
  result_if.source  res_o
);

  // Config registers and the precomputed r^2 * |dir|^2 threshold.
  ray_t            ray;
  logic [ThrW-1:0] thr;

  // Front-to-back queue handshake.
  logic    q_ready, q_push, q_valid, q_pop;
  q_item_t q_push_item, q_item;

  nvr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .ray_o  (ray),
    .thr_o  (thr)
  );

  // Front end: w = v - origin, cross with dir, squared norm. Each request
  // enters the pipe and leaves as one metric plus its last flag.
  nvr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx         (vtx_i),
    .ray_i       (ray),
    .q_ready_i   (q_ready),
    .push_o      (q_push),
    .push_item_o (q_push_item)
  );

  // Small queue so the back end can sit on a stalled result while the
  // front keeps accepting.
  nvr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  // Back end: running minimum, scan index, final threshold test and
  // output register.
  nvr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (q_pop),
    .thr_i     (thr),
    .res       (res_o)
  );

endmodule

[hw/rtl/nvr_cfg.sv]
`timescale 1ns / 1ps
module nvr_cfg import nvr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  cfg_if.sink             cfg,
  output ray_t            ray_o,
  output logic [ThrW-1:0] thr_o
);

  ray_t               ray_q;
  logic [RadiusW-1:0] radius_q;
  logic [RrW-1:0]     rr_q;
  logic [DsqW-1:0]    dsq_q, dsq_d;
  logic [ThrW-1:0]    thr_q;
  logic [CoordW-1:0]  mag_x, mag_y, mag_z;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q    <= '{origin_x: '0, origin_y: '0, origin_z: '0,
                    dir_x: '0, dir_y: '0, dir_z: CoordW'(1)};
      radius_q <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CfgOriginX:    ray_q.origin_x <= cfg.data;
        CfgOriginY:    ray_q.origin_y <= cfg.data;
        CfgOriginZ:    ray_q.origin_z <= cfg.data;
        CfgDirX:       ray_q.dir_x    <= cfg.data;
        CfgDirY:       ray_q.dir_y    <= cfg.data;
        CfgDirZ:       ray_q.dir_z    <= cfg.data;
        CfgPickRadius: radius_q       <= cfg.data[RadiusW-1:0];
        default: ;
      endcase
    end
  end

  // Magnitudes; -2048 maps to 2048, which still fits unsigned.
  assign mag_x = ray_q.dir_x[CoordW-1] ? CoordW'(-ray_q.dir_x) : CoordW'(ray_q.dir_x);
  assign mag_y = ray_q.dir_y[CoordW-1] ? CoordW'(-ray_q.dir_y) : CoordW'(ray_q.dir_y);
  assign mag_z = ray_q.dir_z[CoordW-1] ? CoordW'(-ray_q.dir_z) : CoordW'(ray_q.dir_z);

  assign dsq_d = DsqW'(mag_x) * DsqW'(mag_x) + DsqW'(mag_y) * DsqW'(mag_y)
               + DsqW'(mag_z) * DsqW'(mag_z);

  // After a write, the threshold settles through rr_q or dsq_q, then thr_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q  <= '0;
      dsq_q <= '0;
      thr_q <= '0;
    end else begin
      rr_q  <= RrW'(radius_q) * RrW'(radius_q);
      dsq_q <= dsq_d;
      thr_q <= ThrW'(rr_q) * ThrW'(dsq_q);
    end
  end

  assign ray_o = ray_q;
  assign thr_o = thr_q;

endmodule

[hw/rtl/nvr_front.sv]
`timescale 1ns / 1ps
module nvr_front import nvr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  vertex_if.sink  vtx,
  input  ray_t    ray_i,
  input  logic    q_ready_i,
  output logic    push_o,
  output q_item_t push_item_o
);

  logic                     adv;
  logic                     s1_v_q, s2_v_q, s3_v_q;
  logic                     s1_last_q, s2_last_q, s3_last_q;
  logic signed [WW-1:0]     wx_q, wy_q, wz_q;
  logic signed [CrossW-1:0] cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
  logic [CrossW-1:0]        ax, ay, az;
  logic [SqW-1:0]           sx_q, sy_q, sz_q;

  // Whole pipe moves together; it only stops when the tail can't drain.
  assign adv       = !s3_v_q || q_ready_i;
  assign vtx.ready = adv;

  assign cx_d = CrossW'(wy_q) * CrossW'(ray_i.dir_z) - CrossW'(wz_q) * CrossW'(ray_i.dir_y);
  assign cy_d = CrossW'(wz_q) * CrossW'(ray_i.dir_x) - CrossW'(wx_q) * CrossW'(ray_i.dir_z);
  assign cz_d = CrossW'(wx_q) * CrossW'(ray_i.dir_y) - CrossW'(wy_q) * CrossW'(ray_i.dir_x);

  assign ax = cx_q[CrossW-1] ? CrossW'(-cx_q) : CrossW'(cx_q);
  assign ay = cy_q[CrossW-1] ? CrossW'(-cy_q) : CrossW'(cy_q);
  assign az = cz_q[CrossW-1] ? CrossW'(-cz_q) : CrossW'(cz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= vtx.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx_q      <= WW'(vtx.vertex_x) - WW'(ray_i.origin_x);
      wy_q      <= WW'(vtx.vertex_y) - WW'(ray_i.origin_y);
      wz_q      <= WW'(vtx.vertex_z) - WW'(ray_i.origin_z);
      s1_last_q <= vtx.final_vertex;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      cz_q      <= cz_d;
      s2_last_q <= s1_last_q;
      sx_q      <= SqW'(ax[MagW-1:0]) * SqW'(ax[MagW-1:0]);
      sy_q      <= SqW'(ay[MagW-1:0]) * SqW'(ay[MagW-1:0]);
      sz_q      <= SqW'(az[MagW-1:0]) * SqW'(az[MagW-1:0]);
      s3_last_q <= s2_last_q;
    end
  end

  assign push_o             = s3_v_q && q_ready_i;
  assign push_item_o.last   = s3_last_q;
  assign push_item_o.metric = SumW'(sx_q) + SumW'(sy_q) + SumW'(sz_q);

endmodule

[hw/rtl/nvr_fifo.sv]
`timescale 1ns / 1ps
`include "nearest_vertex_to_ray_unit_macros.svh"
module nvr_fifo import nvr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t push_item_i,
  output logic    ready_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_item_t item_o
);

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntQW = $clog2(FifoDepth + 1);

  q_item_t          mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntQW-1:0] cnt_q;

  assign ready_o = cnt_q != CntQW'(FifoDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntQW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntQW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

  `NVR_ASSERT_SAME(a_no_overflow, clk_i, rst_ni, push_i && !pop_i, ready_o, "fifo overflow")
  `NVR_ASSERT_SAME(a_no_underflow, clk_i, rst_ni, pop_i, valid_o, "fifo underflow")

endmodule

[hw/rtl/nvr_back.sv]
`timescale 1ns / 1ps
`include "nearest_vertex_to_ray_unit_macros.svh"
module nvr_back import nvr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  q_item_t         q_item_i,
  output logic            pop_o,
  input  logic [ThrW-1:0] thr_i,
  result_if.source        res
);

  logic [MetricW-1:0] best_q, best_upd, metric;
  logic [PosW-1:0]    pos_q, pos_upd, idx_q;
  logic [CntW-1:0]    cnt_q;
  logic               res_valid_q, hit_q, in_range, take, hit_d;

  assign pop_o    = q_valid_i && (!res_valid_q || res.ready);
  assign metric   = MetricW'(q_item_i.metric);
  assign in_range = cnt_q < CntW'(MaxVertices);
  assign take     = in_range && (metric < best_q);  // strict: earlier vertex wins ties
  assign best_upd = take ? metric : best_q;
  assign pos_upd  = take ? cnt_q[PosW-1:0] : pos_q;
  assign hit_d    = best_upd < MetricW'(thr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '1;
      pos_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else if (pop_o) begin
      if (q_item_i.last) begin
        best_q      <= '1;
        pos_q       <= '0;
        cnt_q       <= '0;
        res_valid_q <= 1'b1;
      end else begin
        best_q <= best_upd;
        pos_q  <= pos_upd;
        if (in_range) cnt_q <= cnt_q + CntW'(1);
        if (res.ready) res_valid_q <= 1'b0;
      end
    end else if (res.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_item_i.last) begin
      hit_q <= hit_d;
      idx_q <= hit_d ? pos_upd : '0;
    end
  end

  assign res.valid        = res_valid_q;
  assign res.hit          = hit_q;
  assign res.vertex_index = idx_q;

  `NVR_ASSERT_SAME(a_idx_zero_on_miss, clk_i, rst_ni, res_valid_q && !hit_q, idx_q == '0,
    "index not zero on miss")
  `NVR_ASSERT_SAME(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MaxVertices),
    "scan counter past limit")
  `NVR_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, pop_o && q_item_i.last,
    cnt_q == '0 && pos_q == '0 && best_q == '1, "scan state not cleared")
  `NVR_ASSERT_NEXT(a_best_never_grows, clk_i, rst_ni, pop_o && !q_item_i.last,
    best_q <= $past(best_q), "best metric increased mid-scan")

endmodule
